// ===== design/imfu_pkg.sv =====
// Shared constants, command/status structs and helpers for the iterative math function unit.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package imfu_pkg;

  // Number format and iteration limits
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned MAX_ITER  = 32;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned TOL_W     = 17;
  localparam int unsigned DIVD_W    = DATA_W + FRAC_BITS;
  localparam int unsigned DCNT_W    = $clog2(DIVD_W + 1);
  localparam int unsigned K_W       = $clog2(MAX_ITER + 1);
  localparam int unsigned PROD_W    = 2 * (DATA_W + 1);
  localparam int unsigned SUM_W     = DATA_W + 2;

  localparam logic [TOL_W-1:0] TOL_RESET = 17'd66;

  // Fixed-point constants
  localparam logic [DATA_W-1:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] Q_MIN = 32'h8000_0000;

  // Operation codes
  localparam logic [2:0] FN_ADD  = 3'd0;
  localparam logic [2:0] FN_SUB  = 3'd1;
  localparam logic [2:0] FN_MUL  = 3'd2;
  localparam logic [2:0] FN_DIV  = 3'd3;
  localparam logic [2:0] FN_SQRT = 3'd4;
  localparam logic [2:0] FN_COS  = 3'd5;

  // Status codes
  localparam logic [2:0] STS_OK      = 3'd0;
  localparam logic [2:0] STS_DIVZERO = 3'd1;
  localparam logic [2:0] STS_NEGSQRT = 3'd2;
  localparam logic [2:0] STS_NOCONV  = 3'd3;
  localparam logic [2:0] STS_OVF     = 3'd4;

  // Multiplier operand selection
  typedef enum logic [1:0] {
    MUL_AB,
    MUL_SQR,
    MUL_TERM
  } mul_sel_e;

  // Divider operand selection
  typedef enum logic [1:0] {
    DIV_QUOT,
    DIV_SQRT,
    DIV_COS
  } div_sel_e;

  // Final result selection
  typedef enum logic [3:0] {
    FIN_ADDSUB,
    FIN_MUL,
    FIN_DIV,
    FIN_DIVZERO,
    FIN_NEGSQRT,
    FIN_ZERO,
    FIN_T,
    FIN_T_NOCONV,
    FIN_SUM,
    FIN_SUM_NOCONV,
    FIN_COS_OVF_STEP,
    FIN_COS_OVF_XX
  } fin_sel_e;

  // Controller to datapath commands
  typedef struct packed {
    logic     load;
    logic     mul_start;
    mul_sel_e mul_sel;
    logic     div_start;
    div_sel_e div_sel;
    logic     sq_init;
    logic     sq_step;
    logic     cs_init;
    logic     cs_step;
    logic     fin;
    fin_sel_e fin_sel;
    logic     out_push;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [2:0] func;
    logic       a_neg;
    logic       a_zero;
    logic       b_zero;
    logic       div_busy;
    logic       div_done;
    logic       sq_conv;
    logic       k_max;
    logic       cs_more;
    logic       cs_step_ovf;
    logic       xx_ovf;
  } sts_t;

  // Taylor divisor i*(i+1) with i = 2k+1
  function automatic logic [DATA_W-1:0] cos_den(input logic [K_W-1:0] k);
    logic [15:0] i;
    i = (16'(k) << 1) + 16'd1;
    return DATA_W'(i * (i + 16'd1));
  endfunction

endpackage

`default_nettype wire

// ===== design/imfu_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on imfu_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none

module imfu_div
  import imfu_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [DIVD_W-1:0] dvd_i,
  input  wire logic [DATA_W-1:0] dvs_i,
  output logic                   busy_o,
  output logic                   done_o,
  output logic [DIVD_W-1:0]      quo_o
);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [DCNT_W-1:0] cnt_q, cnt_d;
  logic [DIVD_W-1:0] quo_q, quo_d;
  logic [DATA_W-1:0] rem_q, rem_d;
  logic [DATA_W-1:0] dvs_q, dvs_d;
  logic [DATA_W:0]   trial;
  logic [DATA_W:0]   diff;
  logic              fits;

  // One restoring step
  always_comb begin
    trial = {rem_q, quo_q[DIVD_W-1]};
    diff  = trial - {1'b0, dvs_q};
    fits  = trial >= {1'b0, dvs_q};
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DCNT_W'(DIVD_W);
      quo_d  = dvd_i;
      rem_d  = '0;
      dvs_d  = dvs_i;
    end else if (busy_q) begin
      rem_d = fits ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
      quo_d = {quo_q[DIVD_W-2:0], fits};
      cnt_d = cnt_q - DCNT_W'(1);
      if (cnt_q == DCNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Operands and partial results
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

// ===== design/imfu_datapath.sv =====
// Datapath: operand registers, shared multiplier, divider, Newton and Taylor state, output beat.
// Depends on imfu_pkg and imfu_div.
`timescale 1ns / 1ps
`default_nettype none

module imfu_datapath
  import imfu_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [2:0]        in_func_i,
  input  wire logic [DATA_W-1:0] in_a_i,
  input  wire logic [DATA_W-1:0] in_b_i,
  input  wire logic              cfg_we_i,
  input  wire logic [TOL_W-1:0]  cfg_wdata_i,
  input  wire cmd_t              cmd_i,
  output sts_t                   sts_o,
  output logic [DATA_W-1:0]      out_result_o,
  output logic [2:0]             out_status_o
);

  logic [TOL_W-1:0]         tol_q;
  logic [2:0]               func_q;
  logic [DATA_W-1:0]        a_q, b_q;
  logic signed [PROD_W-1:0] prod_q;
  logic [DATA_W-1:0]        t_q;
  logic [K_W-1:0]           k_q;
  logic                     conv_q;
  logic [DATA_W-1:0]        xx_q;
  logic                     xx_ovf_q;
  logic [DATA_W-2:0]        term_q;
  logic signed [SUM_W-1:0]  sum_q;
  logic                     neg_q;
  logic                     step_ovf_q;
  logic [DATA_W-1:0]        ovf_res_q;
  logic [DATA_W-1:0]        res_q;
  logic [2:0]               st_q;
  logic [DATA_W-1:0]        out_res_q;
  logic [2:0]               out_st_q;

  logic [DATA_W-1:0]        mag_a, mag_b;
  logic signed [DATA_W:0]   ma, mb;
  logic [DIVD_W-1:0]        dvd;
  logic [DATA_W-1:0]        dvs;
  logic                     div_busy, div_done;
  logic [DIVD_W-1:0]        quo;

  // Magnitudes
  assign mag_a = a_q[DATA_W-1] ? (~a_q + DATA_W'(1)) : a_q;
  assign mag_b = b_q[DATA_W-1] ? (~b_q + DATA_W'(1)) : b_q;

  // Multiplier operand select
  always_comb begin
    case (cmd_i.mul_sel)
      MUL_AB: begin
        ma = {a_q[DATA_W-1], a_q};
        mb = {b_q[DATA_W-1], b_q};
      end
      MUL_SQR: begin
        ma = {1'b0, mag_a};
        mb = {1'b0, mag_a};
      end
      default: begin
        ma = {2'b0, term_q};
        mb = {1'b0, xx_q};
      end
    endcase
  end

  // Divider operand select
  always_comb begin
    case (cmd_i.div_sel)
      DIV_QUOT: begin
        dvd = {mag_a, FRAC_BITS'(0)};
        dvs = mag_b;
      end
      DIV_SQRT: begin
        dvd = {a_q, FRAC_BITS'(0)};
        dvs = t_q;
      end
      default: begin
        dvd = prod_q[FRAC_BITS+DIVD_W-1:FRAC_BITS];
        dvs = cos_den(k_q);
      end
    endcase
  end

  imfu_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .dvd_i   (dvd),
    .dvs_i   (dvs),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  // Newton step
  logic [DIVD_W:0]   sq_sum;
  logic [DATA_W-1:0] nt, sq_diff;
  always_comb begin
    sq_sum  = {1'b0, DIVD_W'(t_q)} + {1'b0, quo};
    nt      = sq_sum[DATA_W:1];
    sq_diff = (nt >= t_q) ? (nt - t_q) : (t_q - nt);
  end

  // Taylor step
  logic                    term_big;
  logic signed [SUM_W-1:0] snew;
  logic                    snew_ovf;
  always_comb begin
    term_big = |quo[DIVD_W-1:DATA_W-1];
    snew     = neg_q ? (sum_q - $signed({3'b0, quo[DATA_W-2:0]}))
                     : (sum_q + $signed({3'b0, quo[DATA_W-2:0]}));
    snew_ovf = !((&snew[SUM_W-1:DATA_W-1]) || !(|snew[SUM_W-1:DATA_W-1]));
  end

  // Final result select
  logic signed [DATA_W:0]   s33;
  logic signed [PROD_W-1:0] rnd, shr;
  logic                     q_neg;
  logic [DATA_W-1:0]        fin_res;
  logic [2:0]               fin_st;
  always_comb begin
    s33 = (func_q == FN_SUB) ? ($signed({a_q[DATA_W-1], a_q}) - $signed({b_q[DATA_W-1], b_q}))
                             : ($signed({a_q[DATA_W-1], a_q}) + $signed({b_q[DATA_W-1], b_q}));
    rnd   = prod_q + (PROD_W'(1) << (FRAC_BITS - 1));
    shr   = rnd >>> FRAC_BITS;
    q_neg = a_q[DATA_W-1] ^ b_q[DATA_W-1];
    fin_res = '0;
    fin_st  = STS_OK;
    case (cmd_i.fin_sel)
      FIN_ADDSUB: begin
        if (s33[DATA_W] != s33[DATA_W-1]) begin
          fin_res = s33[DATA_W] ? Q_MIN : Q_MAX;
          fin_st  = STS_OVF;
        end else begin
          fin_res = s33[DATA_W-1:0];
        end
      end
      FIN_MUL: begin
        if ((&shr[PROD_W-1:DATA_W-1]) || !(|shr[PROD_W-1:DATA_W-1])) begin
          fin_res = shr[DATA_W-1:0];
        end else begin
          fin_res = shr[PROD_W-1] ? Q_MIN : Q_MAX;
          fin_st  = STS_OVF;
        end
      end
      FIN_DIV: begin
        if (q_neg) begin
          if (quo > DIVD_W'(Q_MIN)) begin
            fin_res = Q_MIN;
            fin_st  = STS_OVF;
          end else begin
            fin_res = ~quo[DATA_W-1:0] + DATA_W'(1);
          end
        end else begin
          if (quo > DIVD_W'(Q_MAX)) begin
            fin_res = Q_MAX;
            fin_st  = STS_OVF;
          end else begin
            fin_res = quo[DATA_W-1:0];
          end
        end
      end
      FIN_DIVZERO: fin_st = STS_DIVZERO;
      FIN_NEGSQRT: fin_st = STS_NEGSQRT;
      FIN_T: fin_res = t_q;
      FIN_T_NOCONV: begin
        fin_res = t_q;
        fin_st  = STS_NOCONV;
      end
      FIN_SUM: fin_res = sum_q[DATA_W-1:0];
      FIN_SUM_NOCONV: begin
        fin_res = sum_q[DATA_W-1:0];
        fin_st  = STS_NOCONV;
      end
      FIN_COS_OVF_STEP: begin
        fin_res = ovf_res_q;
        fin_st  = STS_OVF;
      end
      FIN_COS_OVF_XX: begin
        fin_res = neg_q ? Q_MIN : Q_MAX;
        fin_st  = STS_OVF;
      end
      default: begin
        fin_res = '0;
        fin_st  = STS_OK;
      end
    endcase
  end

  // Tolerance register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TOL_RESET;
    end else if (cfg_we_i) begin
      tol_q <= cfg_wdata_i;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= in_func_i;
      a_q    <= in_a_i;
      b_q    <= in_b_i;
    end
    if (cmd_i.mul_start) begin
      prod_q <= ma * mb;
    end
    if (cmd_i.sq_init) begin
      t_q <= DATA_W'(1) << FRAC_BITS;
      k_q <= '0;
    end
    if (cmd_i.sq_step) begin
      t_q    <= nt;
      k_q    <= k_q + K_W'(1);
      conv_q <= sq_diff < DATA_W'(tol_q);
    end
    if (cmd_i.cs_init) begin
      xx_q       <= prod_q[FRAC_BITS+DATA_W-1:FRAC_BITS];
      xx_ovf_q   <= |prod_q[PROD_W-1:FRAC_BITS+DATA_W];
      term_q     <= (DATA_W-1)'(1) << FRAC_BITS;
      sum_q      <= SUM_W'(1) << FRAC_BITS;
      neg_q      <= 1'b1;
      k_q        <= '0;
      step_ovf_q <= 1'b0;
    end
    if (cmd_i.cs_step) begin
      term_q <= quo[DATA_W-2:0];
      sum_q  <= snew;
      neg_q  <= !neg_q;
      k_q    <= k_q + K_W'(1);
      if (term_big) begin
        step_ovf_q <= 1'b1;
        ovf_res_q  <= neg_q ? Q_MIN : Q_MAX;
      end else if (snew_ovf) begin
        step_ovf_q <= 1'b1;
        ovf_res_q  <= snew[SUM_W-1] ? Q_MIN : Q_MAX;
      end
    end
    if (cmd_i.fin) begin
      res_q <= fin_res;
      st_q  <= fin_st;
    end
    if (cmd_i.out_push) begin
      out_res_q <= res_q;
      out_st_q  <= st_q;
    end
  end

  // Status to controller
  always_comb begin
    sts_o.func        = func_q;
    sts_o.a_neg       = a_q[DATA_W-1];
    sts_o.a_zero      = (a_q == '0);
    sts_o.b_zero      = (b_q == '0);
    sts_o.div_busy    = div_busy;
    sts_o.div_done    = div_done;
    sts_o.sq_conv     = conv_q;
    sts_o.k_max       = (k_q == K_W'(MAX_ITER));
    sts_o.cs_more     = term_q > (DATA_W-1)'(tol_q);
    sts_o.cs_step_ovf = step_ovf_q;
    sts_o.xx_ovf      = xx_ovf_q;
  end

  assign out_result_o = out_res_q;
  assign out_status_o = out_st_q;

endmodule

`default_nettype wire

// ===== design/imfu_ctrl.sv =====
// Controller: sequences load, multiply, divide, iteration and output beats.
// Depends on imfu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module imfu_ctrl
  import imfu_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DISPATCH = 4'd1;
  localparam logic [3:0] S_MUL_RES  = 4'd2;
  localparam logic [3:0] S_DIV_WAIT = 4'd3;
  localparam logic [3:0] S_SQ_DIV   = 4'd4;
  localparam logic [3:0] S_SQ_CHK   = 4'd5;
  localparam logic [3:0] S_CS_XX    = 4'd6;
  localparam logic [3:0] S_CS_CHK   = 4'd7;
  localparam logic [3:0] S_CS_MUL   = 4'd8;
  localparam logic [3:0] S_DONE     = 4'd9;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.mul_sel = MUL_AB;
    cmd_o.div_sel = DIV_QUOT;
    cmd_o.fin_sel = FIN_ZERO;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (sts_i.func)
          FN_ADD, FN_SUB: begin
            cmd_o.fin     = 1'b1;
            cmd_o.fin_sel = FIN_ADDSUB;
            state_d       = S_DONE;
          end
          FN_MUL: begin
            cmd_o.mul_start = 1'b1;
            cmd_o.mul_sel   = MUL_AB;
            state_d         = S_MUL_RES;
          end
          FN_DIV: begin
            if (sts_i.b_zero) begin
              cmd_o.fin     = 1'b1;
              cmd_o.fin_sel = FIN_DIVZERO;
              state_d       = S_DONE;
            end else begin
              cmd_o.div_start = 1'b1;
              cmd_o.div_sel   = DIV_QUOT;
              state_d         = S_DIV_WAIT;
            end
          end
          FN_SQRT: begin
            if (sts_i.a_neg) begin
              cmd_o.fin     = 1'b1;
              cmd_o.fin_sel = FIN_NEGSQRT;
              state_d       = S_DONE;
            end else if (sts_i.a_zero) begin
              cmd_o.fin     = 1'b1;
              cmd_o.fin_sel = FIN_ZERO;
              state_d       = S_DONE;
            end else begin
              cmd_o.sq_init = 1'b1;
              state_d       = S_SQ_DIV;
            end
          end
          FN_COS: begin
            cmd_o.mul_start = 1'b1;
            cmd_o.mul_sel   = MUL_SQR;
            state_d         = S_CS_XX;
          end
          default: begin
            cmd_o.fin     = 1'b1;
            cmd_o.fin_sel = FIN_ZERO;
            state_d       = S_DONE;
          end
        endcase
      end
      S_MUL_RES: begin
        cmd_o.fin     = 1'b1;
        cmd_o.fin_sel = FIN_MUL;
        state_d       = S_DONE;
      end
      S_DIV_WAIT: begin
        if (sts_i.div_done) begin
          if (sts_i.func == FN_SQRT) begin
            cmd_o.sq_step = 1'b1;
            state_d       = S_SQ_CHK;
          end else if (sts_i.func == FN_COS) begin
            cmd_o.cs_step = 1'b1;
            state_d       = S_CS_CHK;
          end else begin
            cmd_o.fin     = 1'b1;
            cmd_o.fin_sel = FIN_DIV;
            state_d       = S_DONE;
          end
        end
      end
      S_SQ_DIV: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_SQRT;
        state_d         = S_DIV_WAIT;
      end
      S_SQ_CHK: begin
        if (sts_i.sq_conv) begin
          cmd_o.fin     = 1'b1;
          cmd_o.fin_sel = FIN_T;
          state_d       = S_DONE;
        end else if (sts_i.k_max) begin
          cmd_o.fin     = 1'b1;
          cmd_o.fin_sel = FIN_T_NOCONV;
          state_d       = S_DONE;
        end else begin
          state_d = S_SQ_DIV;
        end
      end
      S_CS_XX: begin
        cmd_o.cs_init = 1'b1;
        state_d       = S_CS_CHK;
      end
      S_CS_CHK: begin
        // overflow of the last step wins, then the loop test, then the cap
        if (sts_i.cs_step_ovf) begin
          cmd_o.fin     = 1'b1;
          cmd_o.fin_sel = FIN_COS_OVF_STEP;
          state_d       = S_DONE;
        end else if (!sts_i.cs_more) begin
          cmd_o.fin     = 1'b1;
          cmd_o.fin_sel = FIN_SUM;
          state_d       = S_DONE;
        end else if (sts_i.k_max) begin
          cmd_o.fin     = 1'b1;
          cmd_o.fin_sel = FIN_SUM_NOCONV;
          state_d       = S_DONE;
        end else if (sts_i.xx_ovf) begin
          cmd_o.fin     = 1'b1;
          cmd_o.fin_sel = FIN_COS_OVF_XX;
          state_d       = S_DONE;
        end else begin
          cmd_o.mul_start = 1'b1;
          cmd_o.mul_sel   = MUL_TERM;
          state_d         = S_CS_MUL;
        end
      end
      S_CS_MUL: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_COS;
        state_d         = S_DIV_WAIT;
      end
      S_DONE: begin
        if (slot_free) begin
          cmd_o.out_push = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Output beat valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_push) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  // Divider is never restarted mid-run
  a_div_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |-> !sts_i.div_busy)
    else $error("divider restarted while busy");

  // An accepted beat is dispatched next cycle
  a_accept_dispatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_DISPATCH))
    else $error("accepted beat not dispatched");

  // A result is only pushed into a free output slot
  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_push |-> slot_free)
    else $error("output beat overwritten");

  // Divider completion only seen while waiting for it
  a_done_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.div_done |-> (state_q == S_DIV_WAIT))
    else $error("divider result dropped");
`endif

endmodule

`default_nettype wire

// ===== design/iterative_math_function_unit.sv =====
// Top level of the iterative math function unit: stream ports, controller and datapath.
// Depends on imfu_pkg, imfu_ctrl and imfu_datapath.
//
//  channel  direction  beat contents
//  s_axis   in         func, operand_a, operand_b
//  m_axis   out        result, status
//  cfg      in         tolerance write
//
// Add and subtract raise m_axis_tvalid once the result and output registers are loaded; multiply
// first fills the product register, divide runs one divider pass of 48 quotient bits. Square root
// and cosine run one such pass per Newton step or Taylor term, up to 32 steps.
// One item is in work at a time; the next is accepted once the result sits in the
// output register, which holds it until m_axis_tready. Reset clears control and sets
// the tolerance to 66.
`timescale 1ns / 1ps
`default_nettype none

module iterative_math_function_unit
  import imfu_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // [2:0] func, [34:3] operand_a, [66:35] operand_b, [71:67] zero
  input  wire logic [71:0]       s_axis_tdata_i,
  output logic                   m_axis_tvalid_o,
  input  wire logic              m_axis_tready_i,
  // [31:0] result, [34:32] status, [39:35] zero
  output logic [39:0]            m_axis_tdata_o,
  input  wire logic              cfg_we_i,
  input  wire logic [TOL_W-1:0]  cfg_wdata_i
);

  cmd_t              cmd;
  sts_t              sts;
  logic [DATA_W-1:0] out_result;
  logic [2:0]        out_status;

  imfu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  imfu_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_func_i    (s_axis_tdata_i[2:0]),
    .in_a_i       (s_axis_tdata_i[34:3]),
    .in_b_i       (s_axis_tdata_i[66:35]),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_result_o (out_result),
    .out_status_o (out_status)
  );

  assign m_axis_tdata_o = {5'b0, out_status, out_result};

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking bench for the iterative math function unit: directed table, then random phases.
// Depends on imfu_pkg and the iterative_math_function_unit RTL; results checked by a local model.
`timescale 1ns / 1ps

module tb_top;
  import imfu_pkg::*;

  typedef struct packed {
    logic [2:0]  fn;
    logic [31:0] a;
    logic [31:0] b;
    logic        known;
    logic [31:0] r;
    logic [2:0]  s;
  } row_t;

  typedef struct packed {
    logic [31:0] r;
    logic [2:0]  s;
  } res_t;

  localparam int WATCH_LIMIT = 20000;
  localparam int N_ROWS = 26;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_valid = 1'b0;
  logic             s_ready;
  logic [71:0]      s_data = '0;
  logic             m_valid;
  logic             m_ready = 1'b0;
  logic [39:0]      m_data;
  logic             cfg_we = 1'b0;
  logic [TOL_W-1:0] cfg_wdata = '0;

  res_t             want_q[$];
  logic [TOL_W-1:0] tol_model = TOL_RESET;
  int               errors = 0;
  int               idle_cycles = 0;
  bit               calm = 1'b0;     // no idling on either side
  bit               hold_req = 1'b0; // ask receiver for a long hold-off

  always #10 clk_i = ~clk_i;

  iterative_math_function_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata)
  );

  // Directed rows: overflow edges, error codes, unused codes, a few predicted cases
  row_t dir_tab [N_ROWS] = '{
    '{FN_ADD, 32'h7FFFFFFF, 32'h1, 1'b1, Q_MAX, STS_OVF},
    '{FN_ADD, 32'h80000000, 32'hFFFFFFFF, 1'b1, Q_MIN, STS_OVF},
    '{FN_ADD, 32'h10000, 32'h20000, 1'b1, 32'h30000, STS_OK},
    '{FN_SUB, 32'h80000000, 32'h1, 1'b1, Q_MIN, STS_OVF},
    '{FN_SUB, 32'h7FFFFFFF, 32'hFFFFFFFF, 1'b1, Q_MAX, STS_OVF},
    '{FN_SUB, 32'h12345678, 32'h87654321, 1'b0, 32'h0, STS_OK},
    '{FN_MUL, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b1, Q_MAX, STS_OVF},
    '{FN_MUL, 32'h80000000, 32'h80000000, 1'b1, Q_MAX, STS_OVF},
    '{FN_MUL, 32'h80000000, 32'h7FFFFFFF, 1'b1, Q_MIN, STS_OVF},
    '{FN_MUL, 32'h10000, 32'h10000, 1'b1, 32'h10000, STS_OK},
    '{FN_MUL, 32'hFFFFFFFF, 32'h8000, 1'b0, 32'h0, STS_OK},
    '{FN_DIV, 32'h1234, 32'h0, 1'b1, 32'h0, STS_DIVZERO},
    '{FN_DIV, 32'h80000000, 32'hFFFFFFFF, 1'b1, Q_MAX, STS_OVF},
    '{FN_DIV, 32'h10000, 32'h20000, 1'b1, 32'h8000, STS_OK},
    '{FN_DIV, 32'h7FFFFFFF, 32'h1, 1'b1, Q_MAX, STS_OVF},
    '{FN_SQRT, 32'hFFFFFFFF, 32'h0, 1'b1, 32'h0, STS_NEGSQRT},
    '{FN_SQRT, 32'h80000000, 32'h5, 1'b1, 32'h0, STS_NEGSQRT},
    '{FN_SQRT, 32'h0, 32'h0, 1'b1, 32'h0, STS_OK},
    '{FN_SQRT, 32'h40000, 32'h0, 1'b0, 32'h0, STS_OK},
    '{FN_SQRT, 32'h7FFFFFFF, 32'hFFFFFFFF, 1'b0, 32'h0, STS_OK},
    '{FN_COS, 32'h0, 32'h0, 1'b1, 32'h10000, STS_OK},
    '{FN_COS, 32'h80000000, 32'h0, 1'b1, Q_MIN, STS_OVF},
    '{FN_COS, 32'h10000, 32'h0, 1'b0, 32'h0, STS_OK},
    '{FN_COS, 32'hFFFD0000, 32'h0, 1'b0, 32'h0, STS_OK},
    '{3'd6, 32'h11111111, 32'h22222222, 1'b1, 32'h0, STS_OK},
    '{3'd7, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 32'h0, STS_OK}
  };

  // Clamp to 32-bit signed, flag overflow
  function automatic res_t clamp32(input longint v);
    res_t o;
    o.s = STS_OK;
    if (v > 64'sd2147483647) begin
      o.r = Q_MAX;
      o.s = STS_OVF;
    end else if (v < -64'sd2147483648) begin
      o.r = Q_MIN;
      o.s = STS_OVF;
    end else begin
      o.r = v[31:0];
    end
    return o;
  endfunction

  // Newton square root from 1.0
  function automatic res_t newton_sqrt(input longint a);
    res_t o;
    logic [63:0] big, t, nt, d;
    o.s = STS_OK;
    o.r = '0;
    if (a < 0) begin
      o.s = STS_NEGSQRT;
      return o;
    end
    if (a == 0) return o;
    big = 64'(a) << FRAC_BITS;
    t = 64'd1 << FRAC_BITS;
    for (int k = 0; k < MAX_ITER; k++) begin
      nt = (t + big / t) >> 1;
      d = (nt > t) ? nt - t : t - nt;
      t = nt;
      if (d < 64'(tol_model)) begin
        o.r = t[31:0];
        return o;
      end
    end
    o.r = t[31:0];
    o.s = STS_NOCONV;
    return o;
  endfunction

  // Alternating Taylor series for cosine
  function automatic res_t taylor_cos(input longint a);
    res_t o;
    logic [63:0] mag, xx, term, i;
    longint sum;
    bit neg;
    int k;
    mag = (a < 0) ? 64'(-a) : 64'(a);
    xx = (mag * mag) >> FRAC_BITS;
    term = 64'd1 << FRAC_BITS;
    sum = 64'sd65536;
    i = 1;
    neg = 1'b1;
    k = 0;
    o.s = STS_OK;
    while (term > 64'(tol_model)) begin
      if (k >= MAX_ITER) begin
        o.r = sum[31:0];
        o.s = STS_NOCONV;
        return o;
      end
      if (xx > 64'hFFFFFFFF || term > 64'h7FFFFFFF) begin
        o.r = neg ? Q_MIN : Q_MAX;
        o.s = STS_OVF;
        return o;
      end
      term = ((term * xx) >> FRAC_BITS) / (i * (i + 1));
      if (term > 64'h7FFFFFFF) begin
        o.r = neg ? Q_MIN : Q_MAX;
        o.s = STS_OVF;
        return o;
      end
      sum = neg ? sum - longint'(term) : sum + longint'(term);
      if (sum > 64'sd2147483647 || sum < -64'sd2147483648) return clamp32(sum);
      neg = !neg;
      i += 2;
      k++;
    end
    o.r = sum[31:0];
    return o;
  endfunction

  function automatic res_t calc_result(input logic [2:0] fn, input logic [31:0] ua,
                                       input logic [31:0] ub);
    res_t o;
    longint a, b;
    a = longint'($signed(ua));
    b = longint'($signed(ub));
    o = '0;
    case (fn)
      FN_ADD:  o = clamp32(a + b);
      FN_SUB:  o = clamp32(a - b);
      FN_MUL:  o = clamp32((a * b + 64'sd32768) >>> FRAC_BITS);
      FN_DIV:  begin
        if (b == 0) o.s = STS_DIVZERO;
        else o = clamp32((a * 64'sd65536) / b);
      end
      FN_SQRT: o = newton_sqrt(a);
      FN_COS:  o = taylor_cos(a);
      default: o = '0;
    endcase
    return o;
  endfunction

  // Offer one beat; push its expected result once accepted
  task automatic send_beat(input logic [2:0] fn, input logic [31:0] a, input logic [31:0] b,
                           input bit known, input res_t typed);
    s_valid <= 1'b1;
    s_data <= {5'd0, b, a, fn};
    do @(posedge clk_i); while (!s_ready);
    want_q.push_back(known ? typed : calc_result(fn, a, b));
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  endtask

  task automatic drain_and_set_tol(input logic [TOL_W-1:0] tol);
    s_valid <= 1'b0;
    @(posedge clk_i);
    while (want_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= tol;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    tol_model = tol;
  endtask

  function automatic logic [31:0] pick_value(input logic [2:0] fn);
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2: v = $urandom;
      3:       v = ($urandom_range(0, 1) != 0) ? Q_MAX : Q_MIN;
      4:       v = 32'($urandom_range(0, 3)) - 32'd1;
      default: v = 32'($signed($urandom_range(0, 32'h80000))) - 32'sh40000;
    endcase
    // keep most sqrt/cos arguments in the range where the series really runs
    if (fn == FN_COS && $urandom_range(0, 4) != 0) v = {{12{v[19]}}, v[19:0]};
    if (fn == FN_SQRT && $urandom_range(0, 4) != 0) v[31] = 1'b0;
    return v;
  endfunction

  // Stimulus
  initial begin
    logic [2:0] fn;
    logic [TOL_W-1:0] tol_list [6];
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int n = 0; n < N_ROWS; n++)
      send_beat(dir_tab[n].fn, dir_tab[n].a, dir_tab[n].b, dir_tab[n].known,
                '{dir_tab[n].r, dir_tab[n].s});
    tol_list = '{17'd1, 17'd65536, 17'($urandom_range(1, 65536)),
                 17'($urandom_range(1, 300)), 17'h0FFFF, TOL_RESET};
    for (int ph = 0; ph < 6; ph++) begin
      drain_and_set_tol(tol_list[ph]);
      if (ph == 5) calm = 1'b1;
      for (int n = 0; n < 250; n++) begin
        if (ph == 1 && n == 100) hold_req = 1'b1;
        if (ph == 2 && n == 120) begin
          s_valid <= 1'b0;
          @(posedge clk_i);
          while (want_q.size() != 0) @(posedge clk_i);
        end
        fn = ($urandom_range(0, 9) < 6) ? 3'($urandom_range(0, 3)) :
             ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7)) :
             3'($urandom_range(4, 5));
        send_beat(fn, pick_value(fn), pick_value(fn), 1'b0, '0);
      end
    end
    s_valid <= 1'b0;
    while (want_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (errors == 0) $display("PASS iterative_math_function_unit");
    else $display("FAIL iterative_math_function_unit");
    $finish;
  end

  // Receiver ready: random bursts, one long hold-off on request
  initial begin
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_ready <= 1'b0;
        repeat (400) @(posedge clk_i);
      end
      m_ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk_i);
      if (!calm) begin
        m_ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
  end

  // Result check against oldest expectation
  always @(posedge clk_i) begin
    res_t got, want;
    if (m_valid && m_ready) begin
      got = '{m_data[31:0], m_data[34:32]};
      if (want_q.size() == 0) begin
        $display("%0t: unexpected result beat r=%h s=%0d", $time, got.r, got.s);
        errors++;
      end else begin
        want = want_q.pop_front();
        if (got.r !== want.r) begin
          $display("%0t: result mismatch exp=%h act=%h", $time, want.r, got.r);
          errors++;
        end
        if (got.s !== want.s) begin
          $display("%0t: status mismatch exp=%0d act=%0d", $time, want.s, got.s);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any accepted beat or tolerance write
  always @(posedge clk_i) begin
    if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCH_LIMIT) begin
      $display("FAIL iterative_math_function_unit");
      $finish;
    end
  end

endmodule
